>>> src/drt_pkg.sv
package drt_pkg;

  localparam int unsigned NumMarks = 8;
  localparam int unsigned NumDist  = 5;
  localparam int unsigned AccW     = 48;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned MarkW    = 3;

  // Event queue between front and back
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QCntW  = 3;

  // Marks with special timing
  localparam logic [MarkW-1:0] MarkSpeedOne   = 3'd5;
  localparam logic [MarkW-1:0] MarkSpeedTwo   = 3'd6;
  localparam logic [MarkW-1:0] MarkSpeedThree = 3'd7;

  localparam logic [CfgDataW-1:0] MarkReset [NumMarks] = '{
    32'd6583543, 32'd36209488, 32'd72420480, 32'd144840960, 32'd109728000,
    32'd10000, 32'd20000, 32'd30000
  };

  typedef enum logic [1:0] {
    MODE_ARM    = 2'd0,
    MODE_LAUNCH = 2'd1,
    MODE_SAMPLE = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [31:0]       timestamp_ms;
    logic [SpeedW-1:0] speed;
  } in_word_t;

  typedef struct packed {
    logic [MarkW-1:0]  milestone;
    logic [31:0]       time_ms;
    logic [SpeedW-1:0] speed_at;
    logic              last;
  } out_word_t;

  // One sample that crossed at least one mark
  typedef struct packed {
    logic [NumMarks-1:0] hits;
    logic [31:0]         elapsed;
    logic [31:0]         first_split;
    logic [31:0]         second_split;
    logic [SpeedW-1:0]   speed;
  } event_t;

  typedef struct packed {
    logic   valid;
    event_t data;
  } event_port_t;

endpackage

>>> src/drt_front.sv
module drt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  drt_pkg::in_word_t             in_word_i,
  input  logic                          cfg_we_i,
  input  logic [drt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [drt_pkg::CfgDataW-1:0]  cfg_data_i,
  output drt_pkg::event_port_t          evt_o
);
  import drt_pkg::*;

  logic [CfgDataW-1:0] thr_q [NumMarks];

  logic        armed_q, armed_d;
  logic [31:0] start_q, start_d;
  logic [31:0] base_q, base_d;    // start time plus prior elapsed
  logic [31:0] prior_q, prior_d;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_arm_q, s1_arm_d;
  logic [AccW-1:0]   s1_prod_q, s1_prod_d;
  logic [31:0]       s1_elapsed_q, s1_elapsed_d;
  logic [SpeedW-1:0] s1_speed_q, s1_speed_d;
  logic [2:0]        s1_spd_hit_q, s1_spd_hit_d;

  logic [AccW-1:0]     acc_q, acc_d;
  logic [NumMarks-1:0] done_q, done_d;
  logic [31:0]         fs_q, fs_d;
  logic [31:0]         ss_q, ss_d;

  logic [31:0]         elapsed;
  logic [31:0]         step;
  logic [AccW:0]       sum;
  logic [AccW-1:0]     acc_new;
  logic [NumMarks-1:0] hits;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumMarks; i++) begin
        thr_q[i] <= MarkReset[i];
      end
    end else if (cfg_we_i) begin
      for (int i = 0; i < NumMarks; i++) begin
        if (cfg_idx_i == CfgIdxW'(i)) begin
          if (i >= NumDist) begin
            thr_q[i] <= {{(CfgDataW-SpeedW){1'b0}}, cfg_data_i[SpeedW-1:0]};
          end else begin
            thr_q[i] <= cfg_data_i;
          end
        end
      end
    end
  end

  // Stage 1: classify, time step and product
  always_comb begin
    elapsed      = in_word_i.timestamp_ms - start_q;
    step         = in_word_i.timestamp_ms - base_q;
    armed_d      = armed_q;
    start_d      = start_q;
    base_d       = base_q;
    prior_d      = prior_q;
    s1_valid_d   = 1'b0;
    s1_arm_d     = 1'b0;
    s1_prod_d    = AccW'(step) * AccW'(in_word_i.speed);
    s1_elapsed_d = elapsed;
    s1_speed_d   = in_word_i.speed;
    for (int i = 0; i < 3; i++) begin
      s1_spd_hit_d[i] = in_word_i.speed >= thr_q[NumDist+i][SpeedW-1:0];
    end
    if (accept_i) begin
      unique case (in_word_i.mode)
        MODE_ARM: begin
          armed_d    = 1'b1;
          prior_d    = '0;
          base_d     = start_q;
          s1_valid_d = 1'b1;
          s1_arm_d   = 1'b1;
        end
        MODE_LAUNCH: begin
          start_d = in_word_i.timestamp_ms;
          base_d  = in_word_i.timestamp_ms + prior_q;
        end
        MODE_SAMPLE: begin
          if (armed_q) begin
            prior_d    = elapsed;
            base_d     = in_word_i.timestamp_ms;
            s1_valid_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      start_q    <= '0;
      base_q     <= '0;
      prior_q    <= '0;
      s1_valid_q <= 1'b0;
      s1_arm_q   <= 1'b0;
    end else begin
      armed_q    <= armed_d;
      start_q    <= start_d;
      base_q     <= base_d;
      prior_q    <= prior_d;
      s1_valid_q <= s1_valid_d;
      s1_arm_q   <= s1_arm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_prod_q    <= s1_prod_d;
    s1_elapsed_q <= s1_elapsed_d;
    s1_speed_q   <= s1_speed_d;
    s1_spd_hit_q <= s1_spd_hit_d;
  end

  // Stage 2: accumulate, test marks, build event
  always_comb begin
    sum     = {1'b0, acc_q} + {1'b0, s1_prod_q};
    acc_new = sum[AccW] ? '1 : sum[AccW-1:0];
    for (int i = 0; i < NumDist; i++) begin
      hits[i] = !done_q[i] && (acc_new >= AccW'(thr_q[i]));
    end
    for (int i = 0; i < 3; i++) begin
      hits[NumDist+i] = !done_q[NumDist+i] && s1_spd_hit_q[i];
    end
    acc_d  = acc_q;
    done_d = done_q;
    fs_d   = fs_q;
    ss_d   = ss_q;
    evt_o  = '0;
    if (s1_valid_q) begin
      if (s1_arm_q) begin
        acc_d  = '0;
        done_d = '0;
        fs_d   = '0;
        ss_d   = '0;
      end else begin
        acc_d  = acc_new;
        done_d = done_q | hits;
        if (hits[MarkSpeedOne]) begin
          fs_d = s1_elapsed_q;
        end
        if (hits[MarkSpeedTwo]) begin
          ss_d = s1_elapsed_q - fs_d;
        end
        evt_o.valid             = |hits;
        evt_o.data.hits         = hits;
        evt_o.data.elapsed      = s1_elapsed_q;
        evt_o.data.first_split  = fs_d;
        evt_o.data.second_split = ss_d;
        evt_o.data.speed        = s1_speed_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_q <= '0;
      fs_q   <= '0;
      ss_q   <= '0;
    end else begin
      acc_q  <= acc_d;
      done_q <= done_d;
      fs_q   <= fs_d;
      ss_q   <= ss_d;
    end
  end

endmodule

>>> src/drt_fifo.sv
module drt_fifo (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  drt_pkg::event_port_t       wr_i,
  input  logic                       rd_i,
  output drt_pkg::event_port_t       rd_o,
  output logic [drt_pkg::QCntW-1:0]  count_o
);
  import drt_pkg::*;

  event_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;
  logic              do_rd;

  assign do_rd   = rd_i && (count_q != '0);
  assign rd_o    = '{valid: count_q != '0, data: mem_q[rd_ptr_q]};
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.valid) begin
      mem_q[wr_ptr_q] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_i.valid) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCntW'(wr_i.valid) - QCntW'(do_rd);
    end
  end

endmodule

>>> src/drt_back.sv
module drt_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  drt_pkg::event_port_t  evt_i,
  output logic                  evt_rd_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output drt_pkg::out_word_t    out_word_o
);
  import drt_pkg::*;

  logic                work_valid_q, work_valid_d;
  logic [NumMarks-1:0] rem_q, rem_d;
  event_t              work_q;
  logic [MarkW-1:0]    low_idx;
  logic [NumMarks-1:0] low_bit;
  logic                is_last;
  logic                load;

  always_comb begin
    low_idx = '0;
    for (int i = NumMarks - 1; i >= 0; i--) begin
      if (rem_q[i]) begin
        low_idx = MarkW'(i);
      end
    end
    low_bit = rem_q & (~rem_q + 1'b1);
    is_last = (rem_q & ~low_bit) == '0;
  end

  always_comb begin
    out_word_o.milestone = low_idx;
    out_word_o.speed_at  = work_q.speed;
    out_word_o.last      = is_last;
    if (low_idx == MarkSpeedTwo) begin
      out_word_o.time_ms = work_q.second_split;
    end else if (low_idx == MarkSpeedThree) begin
      out_word_o.time_ms = work_q.elapsed - work_q.first_split - work_q.second_split;
    end else begin
      out_word_o.time_ms = work_q.elapsed;
    end
  end

  assign empty_o = !work_valid_q;

  // Advance through the set marks, then take the next event
  always_comb begin
    work_valid_d = work_valid_q;
    rem_d        = rem_q;
    load         = 1'b0;
    if (work_valid_q && pop_i) begin
      rem_d = rem_q & ~low_bit;
      if (is_last) begin
        work_valid_d = 1'b0;
        load         = evt_i.valid;
      end
    end else if (!work_valid_q) begin
      load = evt_i.valid;
    end
    if (load) begin
      work_valid_d = 1'b1;
      rem_d        = evt_i.data.hits;
    end
  end

  assign evt_rd_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      rem_q        <= '0;
    end else begin
      work_valid_q <= work_valid_d;
      rem_q        <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      work_q <= evt_i.data;
    end
  end

endmodule

>>> src/drag_run_milestone_timer.sv
// Acceleration-run milestone timer. Push arm, launch and speed-sample words on
// the input queue port; one input word is taken every cycle while full_o is low.
// Each sample that crosses marks for the first time yields one result word per
// mark, lowest mark first, with last set on its final word; results pass the
// stage-1 registers, the event queue and the back end's work register, and
// leave at one per pop. A sample's product and accumulate run in a two-stage
// front, and crossing events wait in a four-entry queue for the back end that
// spells them out one word per cycle while popped; full_o rises once that
// queue holds three events, so a steady sample stream sustains one word per
// cycle as long as pop keeps up. Distance thresholds are in speed-hundredths
// times milliseconds; write configuration only while no result is pending.
module drag_run_milestone_timer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  drt_pkg::in_word_t             in_word_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output drt_pkg::out_word_t            out_word_o,
  input  logic                          cfg_we_i,
  input  logic [drt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [drt_pkg::CfgDataW-1:0]  cfg_data_i
);
  import drt_pkg::*;

  logic             accept;
  event_port_t      evt_wr;
  event_port_t      evt_rd;
  logic             evt_pop;
  logic [QCntW-1:0] q_count;

  // Hold one slot for the word in the front stage
  assign full_o = q_count >= QCntW'(QDepth - 1);
  assign accept = push_i && !full_o;

  drt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_word_i  (in_word_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .evt_o      (evt_wr)
  );

  drt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (evt_wr),
    .rd_i    (evt_pop),
    .rd_o    (evt_rd),
    .count_o (q_count)
  );

  drt_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_rd),
    .evt_rd_o   (evt_pop),
    .pop_i      (pop_i),
    .empty_o    (empty_o),
    .out_word_o (out_word_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_wr.valid |-> (q_count != QCntW'(QDepth)))
    else $error("event queue written while full");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QDepth))
    else $error("event queue count out of range");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_i && !empty_o && !out_word_o.last) |=> !empty_o)
    else $error("result sequence ended without last");

endmodule

>>> bench/milestone_checker.sv
`timescale 1ns / 100ps

module milestone_checker
  import drt_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                full_i,
  input  in_word_t            in_word_i,
  input  logic                empty_i,
  input  logic                pop_i,
  input  out_word_t           out_word_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  logic [CfgDataW-1:0] marks_q [NumMarks];
  logic                armed_q;
  logic [31:0]         start_q;
  logic [31:0]         prior_q;
  logic [AccW-1:0]     dist_q;
  logic [NumMarks-1:0] done_q;
  logic [31:0]         split1_q;
  logic [31:0]         split2_q;

  out_word_t due_words[$];
  out_word_t want;

  // Advance the run by one input word and queue the milestone words it causes.
  task automatic take_word(input in_word_t w);
    logic [31:0]     elapsed;
    logic [31:0]     step_ms;
    logic [31:0]     t;
    logic [AccW:0]   sum;
    logic [MarkW-1:0] mark;
    logic            hit;
    out_word_t       found [NumMarks];
    int              n;
    n = 0;
    case (w.mode)
      MODE_ARM: begin
        armed_q  = 1'b1;
        prior_q  = '0;
        dist_q   = '0;
        done_q   = '0;
        split1_q = '0;
        split2_q = '0;
      end
      MODE_LAUNCH: start_q = w.timestamp_ms;
      MODE_SAMPLE: begin
        if (armed_q) begin
          elapsed = w.timestamp_ms - start_q;
          step_ms = elapsed - prior_q;
          sum = {1'b0, dist_q} + ((AccW+1)'(step_ms) * (AccW+1)'(w.speed));
          dist_q = sum[AccW] ? '1 : sum[AccW-1:0];
          prior_q = elapsed;
          for (int k = 0; k < NumMarks; k++) begin
            if (!done_q[k]) begin
              if (k < NumDist) begin
                hit = dist_q >= AccW'(marks_q[k]);
              end else begin
                hit = w.speed >= marks_q[k][SpeedW-1:0];
              end
              if (hit) begin
                done_q[k] = 1'b1;
                mark = MarkW'(k);
                if (mark == MarkSpeedOne) begin
                  split1_q = elapsed;
                  t = elapsed;
                end else if (mark == MarkSpeedTwo) begin
                  split2_q = elapsed - split1_q;
                  t = split2_q;
                end else if (mark == MarkSpeedThree) begin
                  t = elapsed - split1_q - split2_q;
                end else begin
                  t = elapsed;
                end
                found[n].milestone = mark;
                found[n].time_ms   = t;
                found[n].speed_at  = w.speed;
                found[n].last      = 1'b0;
                n++;
              end
            end
          end
          for (int i = 0; i < n; i++) begin
            if (i == n - 1) begin
              found[i].last = 1'b1;
            end
            due_words.push_back(found[i]);
          end
        end
      end
      default: ;  // unused mode: drop
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumMarks; k++) begin
        marks_q[k] = MarkReset[k];
      end
      armed_q   = 1'b0;
      start_q   = '0;
      prior_q   = '0;
      dist_q    = '0;
      done_q    = '0;
      split1_q  = '0;
      split2_q  = '0;
      due_words.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        // speed marks keep only their low half
        marks_q[cfg_idx_i] = (cfg_idx_i < NumDist) ? cfg_data_i
                                                   : CfgDataW'(cfg_data_i[SpeedW-1:0]);
      end
      if (push_i && !full_i) begin
        take_word(in_word_i);
      end
      if (pop_i && !empty_i) begin
        if (due_words.size() == 0) begin
          errors_o++;
          $error("milestone: expected none, actual %0d", out_word_i.milestone);
        end else begin
          want = due_words.pop_front();
          if (out_word_i.milestone !== want.milestone) begin
            errors_o++;
            $error("milestone: expected %0d, actual %0d", want.milestone,
                   out_word_i.milestone);
          end
          if (out_word_i.time_ms !== want.time_ms) begin
            errors_o++;
            $error("time_ms: expected %0d, actual %0d", want.time_ms, out_word_i.time_ms);
          end
          if (out_word_i.speed_at !== want.speed_at) begin
            errors_o++;
            $error("speed_at: expected %0d, actual %0d", want.speed_at,
                   out_word_i.speed_at);
          end
          if (out_word_i.last !== want.last) begin
            errors_o++;
            $error("last: expected %0d, actual %0d", want.last, out_word_i.last);
          end
        end
      end
      pending_o = due_words.size();
    end
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import drt_pkg::*;

  localparam logic [1:0] ModeUnused    = 2'b11;
  localparam int         SettleCycles  = 8;
  localparam int         HoldCycles    = 80;
  localparam int         WatchdogLimit = 600;

  typedef enum int {
    PlanDefault,
    PlanZero,
    PlanMax,
    PlanMixed,
    PlanRandom
  } mark_plan_e;

  logic                clk_i;
  logic                rst_ni;
  logic                push_i;
  logic                full_o;
  in_word_t            in_word_i;
  logic                empty_o;
  logic                pop_i;
  out_word_t           out_word_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  int          errors;
  int          pending;
  int          words_sent;
  int          idle_cycles;
  bit          calm;
  bit          hold_req;
  logic [31:0] run_ts;
  int          run_speed;
  int          run_left;

  drag_run_milestone_timer dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_o    (full_o),
    .in_word_i (in_word_i),
    .empty_o   (empty_o),
    .pop_i     (pop_i),
    .out_word_o(out_word_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  milestone_checker u_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push_i),
    .full_i    (full_o),
    .in_word_i (in_word_i),
    .empty_i   (empty_o),
    .pop_i     (pop_i),
    .out_word_i(out_word_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Offer one word; return just after the edge that takes it.
  task automatic send_word(input logic [1:0] mode, input logic [31:0] ts,
                           input logic [SpeedW-1:0] spd);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      push_i = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk_i);
    end
    push_i                 = 1'b1;
    in_word_i.mode         = mode;
    in_word_i.timestamp_ms = ts;
    in_word_i.speed        = spd;
    do @(posedge clk_i); while (full_o);
    words_sent++;
  endtask

  // Hold the input until every predicted word has left, then let the pipe empty.
  task automatic settle();
    @(negedge clk_i);
    push_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic load_marks(input mark_plan_e plan);
    logic [CfgDataW-1:0] val;
    settle();
    for (int i = 0; i < NumMarks; i++) begin
      case (plan)
        PlanDefault: val = MarkReset[i];
        PlanZero:    val = '0;
        PlanMax:     val = '1;
        PlanMixed:   val = $urandom_range(0, 1) ? '1 : '0;
        PlanRandom:  val = (i < NumDist) ? $urandom_range(0, 200_000_000) : $urandom;
        default:     val = MarkReset[i];
      endcase
      @(negedge clk_i);
      cfg_we_i   = 1'b1;
      cfg_idx_i  = CfgIdxW'(i);
      cfg_data_i = val;
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Mostly well-formed runs: arm, launch, then samples with rising speed.
  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (run_left == 0) begin
      send_word(MODE_ARM, $urandom, SpeedW'($urandom));
      run_ts    = $urandom;
      run_speed = $urandom_range(0, 3000);
      run_left  = $urandom_range(6, 20);
      send_word(MODE_LAUNCH, run_ts, SpeedW'($urandom));
    end else if (r < 5) begin
      send_word(ModeUnused, $urandom, SpeedW'($urandom));
    end else if (r < 8) begin
      // jump anywhere in time, backwards included
      send_word(MODE_SAMPLE, $urandom, SpeedW'($urandom));
    end else if (r < 10) begin
      run_ts = $urandom;
      send_word(MODE_LAUNCH, run_ts, SpeedW'($urandom));
    end else begin
      run_ts    += $urandom_range(0, 1500);
      run_speed += $urandom_range(0, 6000);
      if (run_speed > 65535) begin
        run_speed = 65535;
      end
      send_word(MODE_SAMPLE, run_ts, SpeedW'(run_speed));
      run_left--;
    end
  endtask

  task automatic random_phase(input int n);
    int stop;
    stop = words_sent + n;
    while (words_sent < stop) random_item();
  endtask

  // Result side: random stall bursts, plus one long hold on request.
  initial begin
    int stall_left;
    stall_left = 0;
    pop_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        pop_i = 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        pop_i = 1'b0;
        stall_left = $urandom_range(0, 16);
      end else begin
        pop_i = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    rst_ni      = 1'b0;
    push_i      = 1'b0;
    in_word_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    calm        = 1'b0;
    hold_req    = 1'b0;
    words_sent  = 0;
    idle_cycles = 0;
    run_ts      = '0;
    run_speed   = 0;
    run_left    = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // not armed yet: drop
    send_word(MODE_SAMPLE, 32'h0000_1234, 16'hFFFF);
    send_word(ModeUnused, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_ARM, '0, '0);
    // no launch: start time still holds its reset value
    send_word(MODE_SAMPLE, 32'd1000, 16'hFFFF);
    send_word(MODE_LAUNCH, 32'hFFFF_FFF0, 16'h0000);
    send_word(MODE_SAMPLE, 32'h0000_0010, 16'h0000);
    // time runs backwards: step wraps, then the distance saturates
    send_word(MODE_SAMPLE, 32'h0000_0005, 16'hFFFF);
    send_word(MODE_SAMPLE, 32'h0000_0004, 16'hFFFF);
    send_word(ModeUnused, '0, '0);

    load_marks(PlanZero);
    send_word(MODE_ARM, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_SAMPLE, 32'h0000_0004, 16'h0000);

    // every pair crosses all marks while the result side holds off
    hold_req = 1'b1;
    repeat (8) begin
      send_word(MODE_ARM, $urandom, SpeedW'($urandom));
      send_word(MODE_SAMPLE, $urandom, SpeedW'($urandom));
    end

    load_marks(PlanMax);
    send_word(MODE_ARM, '0, '0);
    send_word(MODE_LAUNCH, '0, '0);
    send_word(MODE_SAMPLE, 32'hFFFF_FFFF, 16'hFFFE);
    send_word(MODE_SAMPLE, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(MODE_SAMPLE, 32'hFFFF_FFFE, 16'hFFFF);

    load_marks(PlanDefault);
    random_phase(15);
    load_marks(PlanRandom);
    random_phase(15);
    load_marks(PlanRandom);
    random_phase(15);
    load_marks(PlanMixed);
    random_phase(15);
    load_marks(PlanRandom);
    calm = 1'b1;
    random_phase(18);
    settle();

    if (errors == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
